/* rtl/bez_pkg.sv */
// shared widths and constants for the cubic bezier sampler
// no dependencies
package bez_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_SEG_DEF     = 63;
  localparam int R_W             = 6;   // resolution and sample index
  localparam int DEN_W           = 18;  // r^3 for r up to 63
  localparam int W_W             = 20;  // bernstein weights, up to 63^3
  localparam int HALF_Q          = 2048;
  localparam int NUM_PTS         = 4;
  localparam logic [R_W-1:0] RES_RESET = R_W'(16);

endpackage

/* rtl/bez_if.sv */
// channel interfaces: curve input and sampled point output
// depends on nothing; widths come in through parameters
interface bez_curve_if #(parameter int CW = 24);
  logic valid;
  logic ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] ctrl1_x;
  logic signed [CW-1:0] ctrl1_y;
  logic signed [CW-1:0] ctrl2_x;
  logic signed [CW-1:0] ctrl2_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                end_x, end_y, output ready);
endinterface

interface bez_point_if #(parameter int CW = 24);
  logic valid;
  logic ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic [5:0] sample_number;
  logic last_point;
  modport source (output valid, point_x, point_y, sample_number, last_point, input ready);
  modport sink (input valid, point_x, point_y, sample_number, last_point, output ready);
endinterface

/* rtl/bez_front.sv */
// front end: takes curves, clamps the resolution, holds them in a two-entry queue
// depends on bez_pkg and bez_if
module bez_front #(
  parameter int COORD_WIDTH  = bez_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = bez_pkg::MAX_SEG_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [bez_pkg::R_W-1:0] resolution,
  bez_curve_if.sink curve,
  output logic head_valid,
  input  logic head_pop,
  output logic [bez_pkg::R_W-1:0] head_r,
  output logic [bez_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0] head_xs,
  output logic [bez_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0] head_ys
);
  import bez_pkg::*;

  logic [1:0][R_W-1:0] ent_r;
  logic [1:0][NUM_PTS-1:0][COORD_WIDTH-1:0] ent_xs, ent_ys;
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push;
  logic [R_W-1:0] r_clamped;

  always_comb begin
    if (resolution == '0) begin
      r_clamped = R_W'(1);
    end else if (resolution > R_W'(MAX_SEGMENTS)) begin
      r_clamped = R_W'(MAX_SEGMENTS);
    end else begin
      r_clamped = resolution;
    end
  end

  assign curve.ready = (count != 2'd2);
  assign push        = curve.valid && curve.ready;
  assign head_valid  = (count != 2'd0);
  assign head_r      = ent_r[rd_ptr];
  assign head_xs     = ent_xs[rd_ptr];
  assign head_ys     = ent_ys[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (head_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, head_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr]  <= r_clamped;
      ent_xs[wr_ptr] <= {curve.end_x, curve.ctrl2_x, curve.ctrl1_x, curve.start_x};
      ent_ys[wr_ptr] <= {curve.end_y, curve.ctrl2_y, curve.ctrl1_y, curve.start_y};
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("pop from empty queue");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !head_pop) |=> count == 2'd2)
    else $error("full queue lost an entry");
`endif

endmodule

/* rtl/bez_div.sv */
// restoring divider, one quotient bit per cycle
// depends on bez_pkg
module bez_div #(
  parameter int COORD_WIDTH = bez_pkg::COORD_WIDTH_DEF,
  parameter int ACC_W       = COORD_WIDTH + 20
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ACC_W:0] dividend,
  input  logic [bez_pkg::DEN_W:0] divisor,
  output logic done,
  output logic [COORD_WIDTH-1:0] quotient
);
  import bez_pkg::*;

  localparam int RW    = DEN_W + 2;
  localparam int CNT_W = $clog2(COORD_WIDTH + 1);

  logic [RW-1:0] rem;
  logic [COORD_WIDTH-1:0] low;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [RW-1:0] trial;
  logic fits;

  assign trial = {rem[RW-2:0], low[COORD_WIDTH-1]};
  assign fits  = (trial >= RW'(divisor));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient fits in COORD_WIDTH bits, so the top bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RW'(dividend >> COORD_WIDTH);
      low <= dividend[COORD_WIDTH-1:0];
      cnt <= CNT_W'(COORD_WIDTH);
    end else if (busy) begin
      rem      <= fits ? trial - RW'(divisor) : trial;
      low      <= {low[COORD_WIDTH-2:0], 1'b0};
      quotient <= {quotient[COORD_WIDTH-2:0], fits};
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule

/* rtl/bez_back.sv */
// back end: walks the samples of the head curve, one shared multiply-accumulate per lane,
// then a divide by r^3 with rounding; depends on bez_pkg, bez_div, bez_if
module bez_back #(
  parameter int COORD_WIDTH  = bez_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  output logic head_pop,
  input  logic [bez_pkg::R_W-1:0] head_r,
  input  logic [bez_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0] head_xs,
  input  logic [bez_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0] head_ys,
  bez_point_if.source point
);
  import bez_pkg::*;

  localparam int ACC_W = COORD_WIDTH + 20;
  localparam int VW    = COORD_WIDTH + 14;
  localparam logic signed [VW-1:0] HI = VW'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_CUBE, S_MAC, S_PREP, S_DIV, S_OUT} state_t;

  state_t state;
  logic [R_W-1:0] i_q, a_q;
  logic [2*R_W-1:0] a2, i2, r2;
  logic [NUM_PTS-1:0][W_W-1:0] w_q;
  logic [DEN_W-1:0] den;
  logic [1:0] k;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic neg_x, neg_y;

  logic signed [ACC_W-1:0] w_ext, px_ext, py_ext;
  logic [ACC_W-1:0] mag_x, mag_y;
  logic [ACC_W:0] dvd_x, dvd_y;
  logic [DEN_W:0] dvs;
  logic div_start, done_x, done_y;
  logic [COORD_WIDTH-1:0] q_x, q_y;
  logic signed [VW-1:0] qs_x, qs_y, v_x, v_y;
  logic [COORD_WIDTH-1:0] res_x, res_y;
  logic load;

  assign w_ext  = ACC_W'(w_q[k]);
  assign px_ext = ACC_W'($signed(head_xs[k]));
  assign py_ext = ACC_W'($signed(head_ys[k]));

  assign mag_x = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
  assign mag_y = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
  // round half away from zero: (2*mag + den) / (2*den)
  assign dvd_x = {mag_x, 1'b0} + (ACC_W+1)'(den);
  assign dvd_y = {mag_y, 1'b0} + (ACC_W+1)'(den);
  assign dvs   = {den, 1'b0};
  assign div_start = (state == S_PREP);

  bez_div #(.COORD_WIDTH(COORD_WIDTH), .ACC_W(ACC_W)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_x), .divisor(dvs),
    .done(done_x), .quotient(q_x)
  );
  bez_div #(.COORD_WIDTH(COORD_WIDTH), .ACC_W(ACC_W)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_y), .divisor(dvs),
    .done(done_y), .quotient(q_y)
  );

  // sign, minus one half, saturate
  always_comb begin
    qs_x = VW'(q_x);
    qs_y = VW'(q_y);
    v_x  = (neg_x ? -qs_x : qs_x) - VW'(HALF_Q);
    v_y  = (neg_y ? -qs_y : qs_y) - VW'(HALF_Q);
    if (v_x > HI) begin
      res_x = COORD_WIDTH'(HI);
    end else if (v_x < LO) begin
      res_x = COORD_WIDTH'(LO);
    end else begin
      res_x = COORD_WIDTH'(v_x);
    end
    if (v_y > HI) begin
      res_y = COORD_WIDTH'(HI);
    end else if (v_y < LO) begin
      res_y = COORD_WIDTH'(LO);
    end else begin
      res_y = COORD_WIDTH'(v_y);
    end
  end

  assign load     = (state == S_OUT) && (!point.valid || point.ready);
  assign head_pop = load && (i_q == head_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point.valid <= 1'b0;
    end else begin
      if (load) begin
        point.valid <= 1'b1;
      end else if (point.ready) begin
        point.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= S_SQ;
          end
        end
        S_SQ:   state <= S_CUBE;
        S_CUBE: state <= S_MAC;
        S_MAC: begin
          if (k == 2'd3) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_DIV;
        S_DIV: begin
          if (done_x) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            state <= (i_q == head_r) ? S_IDLE : S_SQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i_q <= '0;
      end
      S_SQ: begin
        a_q <= head_r - i_q;
        a2  <= (2*R_W)'(head_r - i_q) * (2*R_W)'(head_r - i_q);
        i2  <= (2*R_W)'(i_q) * (2*R_W)'(i_q);
        r2  <= (2*R_W)'(head_r) * (2*R_W)'(head_r);
      end
      S_CUBE: begin
        w_q[0] <= W_W'(a2) * W_W'(a_q);
        w_q[1] <= W_W'(a2) * W_W'(i_q) * W_W'(3);
        w_q[2] <= W_W'(i2) * W_W'(a_q) * W_W'(3);
        w_q[3] <= W_W'(i2) * W_W'(i_q);
        den    <= DEN_W'(DEN_W'(r2) * DEN_W'(head_r));
        acc_x  <= '0;
        acc_y  <= '0;
        k      <= 2'd0;
      end
      S_MAC: begin
        acc_x <= acc_x + w_ext * px_ext;
        acc_y <= acc_y + w_ext * py_ext;
        k     <= k + 2'd1;
      end
      S_PREP: begin
        neg_x <= acc_x[ACC_W-1];
        neg_y <= acc_y[ACC_W-1];
      end
      S_OUT: begin
        if (load) begin
          point.point_x       <= res_x;
          point.point_y       <= res_y;
          point.sample_number <= 6'(i_q);
          point.last_point    <= (i_q == head_r);
          i_q                 <= i_q + R_W'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_has_curve: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> head_valid)
    else $error("sampling without a queued curve");
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (i_q <= head_r))
    else $error("sample index past resolution");
  a_lanes_together: assert property (@(posedge clk) disable iff (rst) done_x == done_y)
    else $error("divider lanes out of step");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    done_x |-> (state == S_DIV))
    else $error("divider finished outside divide phase");
`endif

endmodule

/* rtl/cubic_bezier_sampler.sv */
// top level of the cubic bezier sampler: resolution register, front queue, back engine
// depends on bez_pkg, bez_if, bez_front, bez_back, bez_div
//
//   channel  dir  handshake      payload
//   curve    in   valid/ready    start/ctrl1/ctrl2/end x,y (signed q12.12)
//   point    out  valid/ready    point_x, point_y, sample_number, last_point
//   cfg      in   cfg_we         cfg_data = resolution
//
// each sample runs squares, cubes, a multiply-accumulate over the four points and the
// bit-serial divide by r^3, which sets most of its time; a curve gives r+1 samples
// a two-entry queue lets the next curve in while the current one is sampled
// the point register holds a result while the next sample is computed
// rst is synchronous; resolution resets to 16
module cubic_bezier_sampler #(
  parameter int COORD_WIDTH  = bez_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = bez_pkg::MAX_SEG_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bez_pkg::R_W-1:0] cfg_data,
  bez_curve_if.sink curve,
  bez_point_if.source point
);
  import bez_pkg::*;

  logic [R_W-1:0] resolution;
  logic head_valid, head_pop;
  logic [R_W-1:0] head_r;
  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] head_xs, head_ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_RESET;
    end else if (cfg_we) begin
      resolution <= cfg_data;
    end
  end

  bez_front #(.COORD_WIDTH(COORD_WIDTH), .MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk(clk), .rst(rst), .resolution(resolution), .curve(curve),
    .head_valid(head_valid), .head_pop(head_pop), .head_r(head_r),
    .head_xs(head_xs), .head_ys(head_ys)
  );

  bez_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_pop(head_pop),
    .head_r(head_r), .head_xs(head_xs), .head_ys(head_ys), .point(point)
  );

endmodule

/* verif/tb_cubic_bezier_sampler.sv */
// self-checking testbench for cubic_bezier_sampler: directed curves, then random phases
// depends on bez_pkg, bez_if (bez_curve_if, bez_point_if) and the rtl top level
module tb_cubic_bezier_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import bez_pkg::*;

  localparam int CW         = COORD_WIDTH_DEF;
  localparam int IDLE_LIMIT = 40000;
  localparam int SAMPLE_LAT = CW + 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t   x;
    coord_t   y;
    logic [5:0] num;
    logic     last;
  } point_t;

  typedef struct {
    coord_t c[8];   // p0x p0y p1x p1y p2x p2y p3x p3y
    bit     typed;
    coord_t ex;
    coord_t ey;
  } curve_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [R_W-1:0] cfg_data;

  bez_curve_if #(.CW(CW)) curve_ch ();
  bez_point_if #(.CW(CW)) point_ch ();

  cubic_bezier_sampler #(.COORD_WIDTH(CW), .MAX_SEGMENTS(MAX_SEG_DEF)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .curve    (curve_ch),
    .point    (point_ch)
  );

  point_t     pending_pts[$];
  curve_row_t directed_rows[$];
  int         errors = 0;
  int         idle_cycles;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_off;
  int         hold_len;
  int         hold_tag;
  int         hold_seen;
  logic [R_W-1:0] seg_count;

  // segments, curves, send idle %, receive stall %, hold-off cycles
  int phase_tab[10][5] = '{
    '{1,  50, 0,  0,  0},
    '{2,  40, 68, 0,  0},
    '{3,  40, 0,  68, 0},
    '{0,  20, 18, 18, 0},
    '{5,  40, 0,  0,  3000},
    '{63, 4,  18, 18, 0},
    '{4,  40, 68, 68, 0},
    '{1,  40, 0,  68, 0},
    '{8,  20, 18, 18, 0},
    '{2,  30, 0,  0,  0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (pending %0d)", what, got, want,
             pending_pts.size());
  endtask

  // bernstein sum over r^3, round half away from zero, minus one half, saturate
  function automatic coord_t bern_coord(longint p0, longint p1, longint p2, longint p3,
                                        longint r, longint i);
    longint a, num, den, mag, q, v;
    a   = r - i;
    num = a*a*a*p0 + 3*a*a*i*p1 + 3*a*i*i*p2 + i*i*i*p3;
    den = r*r*r;
    mag = (num < 0) ? -num : num;
    q   = (mag*2 + den) / (den*2);
    v   = ((num < 0) ? -q : q) - HALF_Q;
    if (v > longint'(2**(CW-1) - 1)) v = 2**(CW-1) - 1;
    if (v < -longint'(2**(CW-1))) v = -(2**(CW-1));
    return v[CW-1:0];
  endfunction

  function automatic coord_t less_half(coord_t c);
    longint v;
    v = longint'(c) - HALF_Q;
    if (v < -longint'(2**(CW-1))) v = -(2**(CW-1));
    return v[CW-1:0];
  endfunction

  task automatic expect_samples(curve_row_t row);
    point_t p;
    int r;
    r = (seg_count == 0) ? 1 : int'(seg_count);
    for (int i = 0; i <= r; i++) begin
      if (row.typed) begin
        p.x = row.ex;
        p.y = row.ey;
      end else begin
        p.x = bern_coord(row.c[0], row.c[2], row.c[4], row.c[6], r, i);
        p.y = bern_coord(row.c[1], row.c[3], row.c[5], row.c[7], r, i);
      end
      p.num  = i[5:0];
      p.last = (i == r);
      pending_pts.insert(pending_pts.size(), p);
    end
  endtask

  // entered and left at a rising edge; valid stays up across back-to-back transfers
  task automatic send_curve(curve_row_t row);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      curve_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    curve_ch.valid   <= 1'b1;
    curve_ch.start_x <= row.c[0];
    curve_ch.start_y <= row.c[1];
    curve_ch.ctrl1_x <= row.c[2];
    curve_ch.ctrl1_y <= row.c[3];
    curve_ch.ctrl2_x <= row.c[4];
    curve_ch.ctrl2_y <= row.c[5];
    curve_ch.end_x   <= row.c[6];
    curve_ch.end_y   <= row.c[7];
    do @(posedge clk); while (!curve_ch.ready);
    expect_samples(row);
  endtask

  task automatic set_segments(logic [R_W-1:0] v);
    curve_ch.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SAMPLE_LAT + 8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seg_count = v;
  endtask

  function automatic curve_row_t flat_row(coord_t x, coord_t y);
    curve_row_t row;
    for (int k = 0; k < 8; k++) row.c[k] = k[0] ? y : x;
    row.typed = 1'b1;
    row.ex    = less_half(x);
    row.ey    = less_half(y);
    return row;
  endfunction

  function automatic curve_row_t rand_row(int kind);
    curve_row_t row;
    coord_t base;
    row.typed = 1'b0;
    base = coord_t'($urandom);
    for (int k = 0; k < 8; k++) begin
      case (kind)
        0: row.c[k] = coord_t'($urandom);
        1: row.c[k] = base + coord_t'($urandom_range(8191)) - 4096;
        2: row.c[k] = $urandom_range(1) ? coord_t'({1'b0, {(CW-1){1'b1}}})
                                        : coord_t'({1'b1, {(CW-1){1'b0}}});
        default: row.c[k] = coord_t'($urandom_range(255)) - 128;
      endcase
    end
    return row;
  endfunction

  // output side: stall pattern and checking
  always @(posedge clk) begin
    if (rst) begin
      point_ch.ready <= 1'b0;
      hold_off       <= 0;
      hold_seen      <= hold_tag;
    end else if (hold_tag != hold_seen) begin
      hold_seen      <= hold_tag;
      hold_off       <= hold_len;
      point_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      point_ch.ready <= 1'b0;
    end else begin
      point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_pts.size() == 0) begin
        report("unexpected point, sample_number", point_ch.sample_number, -1);
      end else begin
        point_t e;
        e = pending_pts.pop_front();
        if (point_ch.point_x !== e.x) report("point_x", point_ch.point_x, e.x);
        if (point_ch.point_y !== e.y) report("point_y", point_ch.point_y, e.y);
        if (point_ch.sample_number !== e.num)
          report("sample_number", point_ch.sample_number, e.num);
        if (point_ch.last_point !== e.last)
          report("last_point", point_ch.last_point, e.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (curve_ch.valid && curve_ch.ready) || (point_ch.valid && point_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    curve_row_t row;
    hold_len       = 0;
    hold_tag       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    seg_count      = RES_RESET;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    curve_ch.valid   = 1'b0;
    curve_ch.start_x = '0;
    curve_ch.start_y = '0;
    curve_ch.ctrl1_x = '0;
    curve_ch.ctrl1_y = '0;
    curve_ch.ctrl2_x = '0;
    curve_ch.ctrl2_y = '0;
    curve_ch.end_x   = '0;
    curve_ch.end_y   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed curves at the reset resolution; flat curves give p - 1/2 everywhere
    directed_rows.insert(directed_rows.size(), flat_row('0, '0));
    directed_rows.insert(directed_rows.size(),
                         flat_row({1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}));
    directed_rows.insert(directed_rows.size(),
                         flat_row({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}));
    directed_rows.insert(directed_rows.size(), flat_row(coord_t'(HALF_Q), coord_t'(-1)));
    directed_rows.insert(directed_rows.size(),
                         flat_row({1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}}));
    directed_rows.insert(directed_rows.size(),
                         flat_row(coord_t'(-HALF_Q + 1), coord_t'(HALF_Q - 1)));
    // full swing between opposite extremes
    row.typed = 1'b0;
    row.c = '{{1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}},
              {1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}},
              {1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}},
              {1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}};
    directed_rows.insert(directed_rows.size(), row);
    // small odd values to hit rounding ties
    row.c = '{coord_t'(1), coord_t'(-1), coord_t'(3), coord_t'(-3),
              coord_t'(-5), coord_t'(5), coord_t'(7), coord_t'(-7)};
    directed_rows.insert(directed_rows.size(), row);
    for (int k = 0; k < 4; k++) directed_rows.insert(directed_rows.size(), rand_row(k));
    foreach (directed_rows[n]) send_curve(directed_rows[n]);

    foreach (phase_tab[p]) begin
      set_segments(R_W'(phase_tab[p][0]));
      send_idle_pct  = phase_tab[p][2];
      recv_stall_pct = phase_tab[p][3];
      hold_len       = phase_tab[p][4];
      if (hold_len > 0) hold_tag++;
      for (int n = 0; n < phase_tab[p][1]; n++) begin
        int pick;
        pick = $urandom_range(9);
        send_curve(rand_row(pick < 5 ? 0 : pick < 8 ? 1 : pick < 9 ? 2 : 3));
      end
    end

    curve_ch.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (2 * SAMPLE_LAT) @(posedge clk);
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
